### design/blind_motor_limit_controller_top_defines.svh
// Assertion helpers for the blind motor limit controller.
`ifndef BLIND_MOTOR_LIMIT_CONTROLLER_TOP_DEFINES_SVH
`define BLIND_MOTOR_LIMIT_CONTROLLER_TOP_DEFINES_SVH

// Clocked on aclk, disabled while aresetn is low.
`define BMLC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Clocked on aclk, checked during reset too.
`define BMLC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

### design/bmlc_pkg.sv
`default_nettype none

package bmlc_pkg;

    localparam int TICK_COUNT_WIDTH_DEF = 16;
    localparam int LIMIT_W              = 16;
    localparam int CFG_IDX_W            = 1;

    localparam logic [LIMIT_W-1:0] OPEN_LIMIT_RESET  = 16'd720;
    localparam logic [LIMIT_W-1:0] CLOSE_LIMIT_RESET = 16'd600;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OPEN_LIMIT  = 1'b0,
        CFG_CLOSE_LIMIT = 1'b1
    } cfg_index_t;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_ARMED   = 5'b00010,
        PH_MOVING  = 5'b00100,
        PH_ARRIVED = 5'b01000,
        PH_DONE    = 5'b10000
    } phase_t;

    localparam logic [2:0] PH_CODE_IDLE    = 3'd0;
    localparam logic [2:0] PH_CODE_ARMED   = 3'd1;
    localparam logic [2:0] PH_CODE_MOVING  = 3'd2;
    localparam logic [2:0] PH_CODE_ARRIVED = 3'd3;
    localparam logic [2:0] PH_CODE_DONE    = 3'd4;

    // Direction / request bits
    localparam logic [1:0] DIR_NONE  = 2'b00;
    localparam logic [1:0] DIR_OPEN  = 2'b01;
    localparam logic [1:0] DIR_CLOSE = 2'b10;

    // Drive line bit positions
    localparam int LINE_EN    = 0;
    localparam int LINE_CLOSE = 1;
    localparam int LINE_OPEN  = 2;

    typedef struct packed {
        logic request_open;
        logic request_close;
        logic rearm;
        logic top_switch_a;
        logic top_switch_b;
        logic bottom_switch_a;
        logic bottom_switch_b;
    } in_item_t;

    typedef struct packed {
        logic       motor_enable;
        logic       drive_close_line;
        logic       drive_open_line;
        logic [2:0] phase;
        logic       ready_flag;
        logic       timed_out;
        logic       end_reached;
    } out_item_t;

    function automatic logic [2:0] phase_code(phase_t ph);
        logic [2:0] code;
        unique case (ph)
            PH_IDLE:    code = PH_CODE_IDLE;
            PH_ARMED:   code = PH_CODE_ARMED;
            PH_MOVING:  code = PH_CODE_MOVING;
            PH_ARRIVED: code = PH_CODE_ARRIVED;
            default:    code = PH_CODE_DONE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

### design/bmlc_ctrl.sv
`default_nettype none

module bmlc_ctrl #(
    parameter int TICK_COUNT_WIDTH = bmlc_pkg::TICK_COUNT_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          accept,
    input  wire bmlc_pkg::in_item_t            in_item,
    input  wire logic [bmlc_pkg::LIMIT_W-1:0]  open_limit,
    input  wire logic [bmlc_pkg::LIMIT_W-1:0]  close_limit,
    output bmlc_pkg::out_item_t                result
);
    import bmlc_pkg::*;

    `include "blind_motor_limit_controller_top_defines.svh"

    localparam int CMP_W = (TICK_COUNT_WIDTH > LIMIT_W) ? TICK_COUNT_WIDTH : LIMIT_W;

    phase_t                      phase_reg, phase_next;
    logic [1:0]                  dir_reg, dir_next;
    logic [1:0]                  pend_reg, pend_next;
    logic                        ready_reg, ready_next;
    logic [TICK_COUNT_WIDTH-1:0] elapsed_reg, elapsed_next;
    logic [2:0]                  drive_reg, drive_next;

    logic                        top_hit;
    logic                        bottom_hit;
    logic                        at_end;
    logic [LIMIT_W-1:0]          limit;
    logic [TICK_COUNT_WIDTH-1:0] elapsed_inc;
    logic                        timed;
    logic                        ended;

    assign top_hit    = in_item.top_switch_a | in_item.top_switch_b;
    assign bottom_hit = in_item.bottom_switch_a | in_item.bottom_switch_b;

    // saturating tick count
    assign elapsed_inc = (&elapsed_reg) ? elapsed_reg
                                        : elapsed_reg + TICK_COUNT_WIDTH'(1);

    always_comb begin
        phase_next   = phase_reg;
        dir_next     = dir_reg;
        pend_next    = pend_reg | {in_item.request_close, in_item.request_open};
        ready_next   = ready_reg | in_item.rearm;
        elapsed_next = elapsed_reg;
        drive_next   = drive_reg;
        timed        = 1'b0;
        ended        = 1'b0;
        at_end       = 1'b0;
        limit        = open_limit;

        unique case (phase_reg)
            PH_IDLE: begin
                if (pend_next != DIR_NONE) begin
                    dir_next   = pend_next;
                    phase_next = PH_ARMED;
                end
            end
            PH_ARMED: begin
                if (ready_next && (dir_reg == DIR_OPEN || dir_reg == DIR_CLOSE)) begin
                    elapsed_next          = '0;
                    drive_next            = '0;
                    drive_next[LINE_EN]   = 1'b1;
                    drive_next[LINE_OPEN] = (dir_reg == DIR_OPEN);
                    drive_next[LINE_CLOSE] = (dir_reg == DIR_CLOSE);
                    phase_next            = PH_MOVING;
                end else begin
                    phase_next = PH_DONE;
                end
            end
            PH_MOVING: begin
                priority if (dir_reg == DIR_OPEN || dir_reg == DIR_CLOSE) begin
                    at_end = (dir_reg == DIR_OPEN) ? top_hit : bottom_hit;
                    limit  = (dir_reg == DIR_OPEN) ? open_limit : close_limit;
                    if (at_end) begin
                        drive_next   = '0;
                        elapsed_next = '0;
                        ended        = 1'b1;
                        phase_next   = PH_ARRIVED;
                    end else if (CMP_W'(elapsed_inc) > CMP_W'(limit)) begin
                        drive_next   = '0;
                        elapsed_next = '0;
                        ready_next   = 1'b0;
                        timed        = 1'b1;
                        phase_next   = PH_DONE;
                    end else begin
                        elapsed_next = elapsed_inc;
                    end
                end else begin
                    // no valid direction
                    drive_next   = '0;
                    elapsed_next = '0;
                    phase_next   = PH_DONE;
                end
            end
            PH_ARRIVED: begin
                phase_next = PH_DONE;
            end
            default: begin
                pend_next  = DIR_NONE;
                dir_next   = DIR_NONE;
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_comb begin
        result.motor_enable     = drive_next[LINE_EN];
        result.drive_close_line = drive_next[LINE_CLOSE];
        result.drive_open_line  = drive_next[LINE_OPEN];
        result.phase            = phase_code(phase_next);
        result.ready_flag       = ready_next;
        result.timed_out        = timed;
        result.end_reached      = ended;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            dir_reg     <= DIR_NONE;
            pend_reg    <= DIR_NONE;
            ready_reg   <= 1'b1;
            elapsed_reg <= '0;
            drive_reg   <= '0;
        end else if (accept) begin
            phase_reg   <= phase_next;
            dir_reg     <= dir_next;
            pend_reg    <= pend_next;
            ready_reg   <= ready_next;
            elapsed_reg <= elapsed_next;
            drive_reg   <= drive_next;
        end
    end

    `BMLC_ASSERT(a_arrived_to_done,
        (accept && phase_reg == PH_ARRIVED) |=> (phase_reg == PH_DONE),
        "arrived phase did not advance to done")
    `BMLC_ASSERT(a_timeout_clears_ready,
        (accept && result.timed_out) |=> (!ready_reg && drive_reg == 3'b000),
        "timeout left ready set or motor driven")
    `BMLC_ASSERT(a_one_line_when_enabled,
        drive_reg[LINE_EN] |-> $onehot({drive_reg[LINE_OPEN], drive_reg[LINE_CLOSE]}),
        "enabled motor without exactly one direction line")
    `BMLC_ASSERT(a_driven_only_moving,
        (drive_reg != 3'b000) |-> (phase_reg == PH_MOVING),
        "drive lines active outside moving phase")

endmodule

`default_nettype wire

### design/blind_motor_limit_controller_top.sv
`default_nettype none

// Blind motor limit controller. One input item is one tick; every accepted item
// yields exactly one result item showing the drive lines, phase code, ready flag
// and the timeout / end-switch strobes after that tick. An item can be accepted
// every cycle while the skid is empty; its result is registered in the result
// register, or in the skid on a stall. The limit is set by the single pass
// through the phase logic and tick compare between the state registers and
// the result register. A two-entry buffer (result register plus skid) keeps
// s_ready high until the skid fills; one item per cycle while m_ready is high.
// Write the tick limits through cfg_we/cfg_index/cfg_wdata only while idle.
module blind_motor_limit_controller_top #(
    parameter int TICK_COUNT_WIDTH = bmlc_pkg::TICK_COUNT_WIDTH_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire bmlc_pkg::in_item_t             s_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output bmlc_pkg::out_item_t                 m_data,
    input  wire logic                           cfg_we,
    input  wire logic [bmlc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bmlc_pkg::LIMIT_W-1:0]   cfg_wdata
);
    import bmlc_pkg::*;

    `include "blind_motor_limit_controller_top_defines.svh"

    logic [LIMIT_W-1:0] open_limit_reg;
    logic [LIMIT_W-1:0] close_limit_reg;
    out_item_t          result;
    logic               accept;
    logic               take;

    logic               out_valid_reg, out_valid_next;
    logic               skid_valid_reg, skid_valid_next;
    out_item_t          out_data_reg, out_data_next;
    out_item_t          skid_data_reg, skid_data_next;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign take    = out_valid_reg && m_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_limit_reg  <= OPEN_LIMIT_RESET;
            close_limit_reg <= CLOSE_LIMIT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_OPEN_LIMIT:  open_limit_reg  <= cfg_wdata;
                CFG_CLOSE_LIMIT: close_limit_reg <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    bmlc_ctrl #(
        .TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .in_item    (s_data),
        .open_limit (open_limit_reg),
        .close_limit(close_limit_reg),
        .result     (result)
    );

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || take) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = accept;
                out_data_next  = result;
            end
        end else if (accept) begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    `BMLC_ASSERT(a_skid_behind_out,
        skid_valid_reg |-> out_valid_reg,
        "skid holds an item while the result register is empty")
    `BMLC_ASSERT(a_accept_shows_result,
        accept |=> out_valid_reg,
        "accepted item produced no result")
    `BMLC_ASSERT(a_stall_fills_skid,
        (accept && out_valid_reg && !m_ready) |=> (skid_valid_reg && !s_ready),
        "stalled result did not park the new item in the skid")

endmodule

`default_nettype wire

### verif/blind_motor_limit_controller_checker.sv
module blind_motor_limit_controller_checker #(
    parameter int TICK_COUNT_WIDTH = bmlc_pkg::TICK_COUNT_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  bmlc_pkg::in_item_t             s_data,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  bmlc_pkg::out_item_t            m_data,
    input  logic                           cfg_we,
    input  logic [bmlc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bmlc_pkg::LIMIT_W-1:0]   cfg_wdata,
    output int                             fail_count,
    output int                             pending_count
);
    import bmlc_pkg::*;

    logic [2:0]                  phase_q;
    logic [1:0]                  dir_q;
    logic [1:0]                  req_q;
    logic                        ready_q;
    logic [TICK_COUNT_WIDTH-1:0] ticks_q;
    logic [2:0]                  lines_q;
    logic [LIMIT_W-1:0]          open_lim;
    logic [LIMIT_W-1:0]          close_lim;
    out_item_t                   due_results[$];
    out_item_t                   want;
    int                          errs = 0;

    function automatic out_item_t advance_tick(in_item_t it);
        logic               timed;
        logic               ended;
        logic               top;
        logic               bottom;
        logic               at_end;
        logic [LIMIT_W-1:0] lim;
        out_item_t          r;
        timed  = 1'b0;
        ended  = 1'b0;
        at_end = 1'b0;
        lim    = '0;
        top    = it.top_switch_a | it.top_switch_b;
        bottom = it.bottom_switch_a | it.bottom_switch_b;
        if (it.request_open) req_q = req_q | DIR_OPEN;
        if (it.request_close) req_q = req_q | DIR_CLOSE;
        if (it.rearm) ready_q = 1'b1;
        case (phase_q)
            PH_CODE_IDLE: begin
                if (req_q != DIR_NONE) begin
                    dir_q   = req_q;
                    phase_q = PH_CODE_ARMED;
                end
            end
            PH_CODE_ARMED: begin
                if (ready_q && (dir_q == DIR_OPEN || dir_q == DIR_CLOSE)) begin
                    ticks_q = '0;
                    lines_q = '0;
                    lines_q[LINE_EN] = 1'b1;
                    lines_q[(dir_q == DIR_OPEN) ? LINE_OPEN : LINE_CLOSE] = 1'b1;
                    phase_q = PH_CODE_MOVING;
                end else begin
                    phase_q = PH_CODE_DONE;
                end
            end
            PH_CODE_MOVING: begin
                if (dir_q == DIR_OPEN) begin
                    at_end = top;
                    lim    = open_lim;
                end else if (dir_q == DIR_CLOSE) begin
                    at_end = bottom;
                    lim    = close_lim;
                end
                if (dir_q != DIR_OPEN && dir_q != DIR_CLOSE) begin
                    lines_q = '0;
                    ticks_q = '0;
                    phase_q = PH_CODE_DONE;
                end else if (at_end) begin
                    lines_q = '0;
                    ticks_q = '0;
                    ended   = 1'b1;
                    phase_q = PH_CODE_ARRIVED;
                end else begin
                    if (ticks_q != '1) ticks_q = ticks_q + 1'b1;
                    if (ticks_q > lim) begin
                        lines_q = '0;
                        ticks_q = '0;
                        ready_q = 1'b0;
                        timed   = 1'b1;
                        phase_q = PH_CODE_DONE;
                    end
                end
            end
            PH_CODE_ARRIVED: phase_q = PH_CODE_DONE;
            default: begin
                req_q   = DIR_NONE;
                dir_q   = DIR_NONE;
                phase_q = PH_CODE_IDLE;
            end
        endcase
        r.motor_enable     = lines_q[LINE_EN];
        r.drive_close_line = lines_q[LINE_CLOSE];
        r.drive_open_line  = lines_q[LINE_OPEN];
        r.phase            = phase_q;
        r.ready_flag       = ready_q;
        r.timed_out        = timed;
        r.end_reached      = ended;
        return r;
    endfunction

    function automatic int differs(string field, logic [2:0] exp_val, logic [2:0] got);
        if (got !== exp_val) begin
            $display("%0t: %s expected %0d, got %0d", $time, field, exp_val, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            phase_q   = PH_CODE_IDLE;
            dir_q     = DIR_NONE;
            req_q     = DIR_NONE;
            ready_q   = 1'b1;
            ticks_q   = '0;
            lines_q   = '0;
            open_lim  = OPEN_LIMIT_RESET;
            close_lim = CLOSE_LIMIT_RESET;
            due_results.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_OPEN_LIMIT) open_lim = cfg_wdata;
                else if (cfg_index == CFG_CLOSE_LIMIT) close_lim = cfg_wdata;
            end
            if (s_valid && s_ready) due_results.push_back(advance_tick(s_data));
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    $display("%0t: result %p with none expected", $time, m_data);
                    errs++;
                end else begin
                    want = due_results.pop_front();
                    errs += differs("motor_enable", 3'(want.motor_enable),
                                    3'(m_data.motor_enable));
                    errs += differs("drive_close_line", 3'(want.drive_close_line),
                                    3'(m_data.drive_close_line));
                    errs += differs("drive_open_line", 3'(want.drive_open_line),
                                    3'(m_data.drive_open_line));
                    errs += differs("phase", want.phase, m_data.phase);
                    errs += differs("ready_flag", 3'(want.ready_flag),
                                    3'(m_data.ready_flag));
                    errs += differs("timed_out", 3'(want.timed_out),
                                    3'(m_data.timed_out));
                    errs += differs("end_reached", 3'(want.end_reached),
                                    3'(m_data.end_reached));
                end
            end
        end
        fail_count    <= errs;
        pending_count <= due_results.size();
    end

endmodule

### verif/blind_motor_limit_controller_top_tb.sv
module blind_motor_limit_controller_top_tb;
    import bmlc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    in_item_t           s_data;
    logic               m_valid;
    logic               m_ready;
    out_item_t          m_data;
    logic               cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LIMIT_W-1:0] cfg_wdata;
    int                 fail_count;
    int                 pending_count;
    int                 cycles = 0;
    int                 rx_cycles = 0;
    int                 items_sent = 0;
    logic [LIMIT_W-1:0] lim_open;
    logic [LIMIT_W-1:0] lim_close;

    always #5 aclk = ~aclk;

    blind_motor_limit_controller_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    blind_motor_limit_controller_checker motor_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // long hold-off first, then a stretch with no stalls
    always @(posedge aclk) begin
        rx_cycles <= rx_cycles + 1;
        if (rx_cycles >= 200 && rx_cycles < 500) begin
            m_ready <= 1'b0;
        end else if (rx_cycles >= 600 && rx_cycles < 1000) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= 25);
        end
    end

    function automatic in_item_t mk(int ro, int rc, int re, int ta, int tb,
                                    int ba, int bb);
        in_item_t it;
        it.request_open    = 1'(ro);
        it.request_close   = 1'(rc);
        it.rearm           = 1'(re);
        it.top_switch_a    = 1'(ta);
        it.top_switch_b    = 1'(tb);
        it.bottom_switch_a = 1'(ba);
        it.bottom_switch_b = 1'(bb);
        return it;
    endfunction

    function automatic in_item_t noise_item();
        logic [6:0] bits;
        bits = 7'($urandom);
        return in_item_t'(bits);
    endfunction

    // set the end switches of the travel direction
    function automatic in_item_t with_end(in_item_t it, logic opening, logic [1:0] sw);
        if (opening) begin
            it.top_switch_a = sw[0];
            it.top_switch_b = sw[1];
        end else begin
            it.bottom_switch_a = sw[0];
            it.bottom_switch_b = sw[1];
        end
        return it;
    endfunction

    task automatic put(in_item_t it);
        if (!(items_sent >= 400 && items_sent < 550) && $urandom_range(99) < 15) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
        items_sent++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // switches all active, no requests: walks any phase back to idle, then writes both limits
    task automatic set_limits(logic [LIMIT_W-1:0] o, logic [LIMIT_W-1:0] c);
        repeat (6) put(mk(0, 0, 0, 1, 1, 1, 1));
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_OPEN_LIMIT;
        cfg_wdata <= o;
        @(posedge aclk);
        cfg_index <= CFG_CLOSE_LIMIT;
        cfg_wdata <= c;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        lim_open  = o;
        lim_close = c;
    endtask

    task automatic move_episode(logic [1:0] req, logic rearm_first, int travel, logic hit_end);
        in_item_t it;
        it = noise_item();
        it.request_open  = req[0];
        it.request_close = req[1];
        it.rearm         = rearm_first;
        put(it);
        it = noise_item();
        it.rearm = ($urandom_range(99) < 10);
        put(it);
        repeat (travel) begin
            it = noise_item();
            it.rearm = ($urandom_range(99) < 10);
            put(with_end(it, req[0], 2'b00));
        end
        if (hit_end) begin
            it = noise_item();
            it.rearm = ($urandom_range(99) < 10);
            put(with_end(it, req[0], 2'($urandom_range(1, 3))));
        end
        repeat (2) begin
            it = noise_item();
            if ($urandom_range(99) >= 20) begin
                it.request_open  = 1'b0;
                it.request_close = 1'b0;
            end
            put(it);
        end
    endtask

    initial begin
        int                 target;
        logic [1:0]         req;
        logic [LIMIT_W-1:0] lim;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        m_ready   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_OPEN_LIMIT;
        cfg_wdata <= '0;
        lim_open  = OPEN_LIMIT_RESET;
        lim_close = CLOSE_LIMIT_RESET;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset limits: open to top switch past a wrong-side switch, close to bottom
        put(mk(1, 0, 0, 0, 0, 0, 0));
        put(mk(0, 0, 0, 0, 0, 0, 0));
        put(mk(0, 0, 0, 0, 0, 1, 1));
        put(mk(0, 0, 0, 1, 0, 0, 0));
        put(mk(0, 0, 0, 0, 0, 0, 0));
        put(mk(0, 1, 0, 0, 0, 0, 0));  // request on a done tick is dropped
        put(mk(0, 1, 0, 0, 0, 0, 0));
        put(mk(0, 0, 0, 0, 0, 0, 0));
        put(mk(0, 0, 0, 1, 1, 0, 1));
        put(mk(0, 0, 0, 0, 0, 0, 0));
        put(mk(0, 0, 0, 0, 0, 0, 0));
        put(mk(1, 1, 0, 0, 0, 0, 0));  // both directions: no move
        put(mk(0, 0, 0, 0, 0, 0, 0));
        put(mk(0, 0, 0, 0, 0, 0, 0));

        set_limits(16'd2, 16'd0);
        put(mk(1, 0, 0, 0, 0, 0, 0));  // open move times out
        repeat (4) put(mk(0, 0, 0, 0, 0, 0, 0));
        put(mk(0, 0, 0, 0, 0, 0, 0));
        put(mk(0, 1, 0, 0, 0, 0, 0));  // not ready: done without moving
        put(mk(0, 0, 0, 0, 0, 0, 0));
        put(mk(0, 0, 0, 0, 0, 0, 0));
        put(mk(0, 1, 1, 0, 0, 0, 0));
        put(mk(0, 0, 0, 0, 0, 0, 0));
        put(mk(0, 0, 1, 1, 1, 0, 0));  // rearm on the timeout tick
        put(mk(0, 0, 0, 0, 0, 0, 0));
        put(mk(1, 1, 1, 1, 1, 1, 1));
        put(mk(0, 0, 0, 0, 0, 0, 0));
        put(mk(0, 0, 0, 0, 0, 0, 0));

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: set_limits(OPEN_LIMIT_RESET, CLOSE_LIMIT_RESET);
                1: set_limits(16'd0, 16'hFFFF);
                2: set_limits(16'hFFFF, 16'd0);
                3: set_limits(16'd1, 16'd2);
                4: set_limits(16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)));
                default: set_limits(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 60)));
            endcase
            target = items_sent + 100;
            while (items_sent < target) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5, 6: begin
                        req = $urandom_range(0, 1) ? DIR_OPEN : DIR_CLOSE;
                        lim = (req == DIR_OPEN) ? lim_open : lim_close;
                        if (lim <= 40 && $urandom_range(99) < 35) begin
                            move_episode(req, $urandom_range(99) < 60, lim + 1, 1'b0);
                        end else begin
                            move_episode(req, $urandom_range(99) < 60,
                                         $urandom_range(0, (lim < 30) ? lim : 30), 1'b1);
                        end
                    end
                    7: move_episode(DIR_OPEN | DIR_CLOSE, 1'($urandom_range(0, 1)),
                                    $urandom_range(0, 3), 1'($urandom_range(0, 1)));
                    default: repeat ($urandom_range(1, 6)) put(noise_item());
                endcase
            end
        end

        settle();
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
